// ===== rtl/swld_pkg.sv =====
// shared types and constants for the sync word length deframer
// no dependencies; imported by sync_word_length_deframer
`timescale 1ns / 1ps

package swld_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned LEN_W    = 34;
  localparam int unsigned HSIZE_W  = 16;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CIDX_W   = 2;
  localparam int unsigned HOLD_W   = 3;
  localparam int unsigned HDR_HELD = 7;
  localparam int unsigned OUT_W    = BYTE_W + 2 * WORD_W;

  localparam logic [WORD_W-1:0] SYNC_WORD = 32'hAAAA_AAAA;
  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hAA;
  localparam logic [LEN_W-1:0]  HDR_BYTES = 34'd8;

  localparam logic [HSIZE_W-1:0] HSIZE_RST   = 16'd32;
  localparam logic [WORD_W-1:0]  MAXPAY_RST  = 32'd65536;
  localparam logic [WORD_W-1:0]  DISCARD_MAX = 32'hFFFF_FFFF;

  localparam logic [HOLD_W-1:0] HELD_HUNT_DONE = 3'd4;
  localparam logic [HOLD_W-1:0] HELD_HDR_LAST  = 3'd7;

  typedef enum logic [CIDX_W-1:0] {
    CFG_HEADER_SIZE = 2'd0,
    CFG_MAX_PAYLOAD = 2'd1
  } cfg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE      = 2'd0,
    KIND_HEADER    = 2'd1,
    KIND_LEN_SHORT = 2'd2,
    KIND_TOO_LARGE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    MODE_ALIGNED = 3'b001,
    MODE_HUNT    = 3'b010,
    MODE_PAYLOAD = 3'b100
  } mode_t;

endpackage

// ===== rtl/sync_word_length_deframer.sv =====
// a result is registered and presented in the cycle after the byte that causes it is transferred
// throughput: one byte per cycle; a byte is taken whenever the result register is empty
//   or being drained, so only out_tready limits the rate
// reset (rst_n low, synchronous): aligned header collection, no bytes held, discard count
//   zero, header_size_bytes 32, max_payload_bytes 65536, no result pending
// depends on swld_pkg
`timescale 1ns / 1ps

module sync_word_length_deframer
  import swld_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [BYTE_W-1:0]    in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // [7:0] byte_out, [39:8] packet_words,
                                           // [71:40] discarded_total
  output logic [KIND_W-1:0]    out_tuser,  // [1:0] kind
  output logic                 out_tlast,  // last
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CIDX_W-1:0]    cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  logic [HSIZE_W-1:0] hsize_r;
  logic [WORD_W-1:0]  maxpay_r;

  mode_t              mode_r, mode_nxt;
  logic [HOLD_W-1:0]  held_r, held_nxt;
  logic [BYTE_W-1:0]  hdr_r [HDR_HELD];
  logic [LEN_W-1:0]   remain_r, remain_nxt;
  logic [WORD_W-1:0]  discard_r, discard_nxt;

  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic [WORD_W-1:0]  out_words_r;
  logic               out_last_r;
  logic [WORD_W-1:0]  out_disc_r;

  logic               in_fire;
  logic               hdr_wr;
  logic               res_valid;
  kind_t              res_kind;
  logic [BYTE_W-1:0]  res_byte;
  logic [WORD_W-1:0]  res_words;
  logic               res_last;

  logic [WORD_W-1:0]  w0, w1;
  logic [LEN_W-1:0]   plen, payload;
  logic               disc_en;
  logic [3:0]         disc_add;
  logic [WORD_W:0]    disc_sum;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hsize_r  <= HSIZE_RST;
      maxpay_r <= MAXPAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEADER_SIZE: hsize_r  <= cfg_data[HSIZE_W-1:0];
        CFG_MAX_PAYLOAD: maxpay_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // header words: the eighth byte is the one arriving now
  assign w0      = {hdr_r[3], hdr_r[2], hdr_r[1], hdr_r[0]};
  assign w1      = {in_tdata, hdr_r[6], hdr_r[5], hdr_r[4]};
  assign plen    = {w1, 2'b00};
  assign payload = plen - LEN_W'(hsize_r);

  assign disc_sum = {1'b0, discard_r} + (WORD_W + 1)'(disc_add);

  always_comb begin
    mode_nxt    = mode_r;
    held_nxt    = held_r;
    remain_nxt  = remain_r;
    hdr_wr      = 1'b0;
    disc_en     = 1'b0;
    disc_add    = '0;
    res_valid   = 1'b0;
    res_kind    = KIND_BYTE;
    res_byte    = '0;
    res_words   = '0;
    res_last    = 1'b0;

    unique case (mode_r)
      MODE_PAYLOAD: begin
        remain_nxt = remain_r - LEN_W'(1);
        res_valid  = 1'b1;
        res_byte   = in_tdata;
        if (remain_r == LEN_W'(1)) begin
          mode_nxt = MODE_ALIGNED;
          held_nxt = '0;
          res_last = 1'b1;
        end
      end
      MODE_HUNT: begin
        if (in_tdata != SYNC_BYTE) begin
          // broken run: held sync bytes and this one are dropped
          disc_en  = 1'b1;
          disc_add = {1'b0, held_r} + 4'd1;
          held_nxt = '0;
        end else begin
          hdr_wr   = 1'b1;
          held_nxt = held_r + HOLD_W'(1);
          if (held_nxt == HELD_HUNT_DONE) begin
            mode_nxt = MODE_ALIGNED;
          end
        end
      end
      MODE_ALIGNED: begin
        if (held_r != HELD_HDR_LAST) begin
          hdr_wr   = 1'b1;
          held_nxt = held_r + HOLD_W'(1);
        end else begin
          held_nxt  = '0;
          res_words = w1;
          res_last  = 1'b1;
          if (w0 != SYNC_WORD) begin
            disc_en  = 1'b1;
            disc_add = 4'd8;
            mode_nxt = MODE_HUNT;
          end else if (plen < LEN_W'(hsize_r)) begin
            res_valid = 1'b1;
            res_kind  = KIND_LEN_SHORT;
          end else if (payload > LEN_W'(maxpay_r)) begin
            res_valid = 1'b1;
            res_kind  = KIND_TOO_LARGE;
          end else if (plen <= HDR_BYTES) begin
            res_valid  = 1'b1;
            res_kind   = KIND_HEADER;
            remain_nxt = '0;
          end else begin
            res_valid  = 1'b1;
            res_kind   = KIND_HEADER;
            res_last   = 1'b0;
            remain_nxt = plen - HDR_BYTES;
            mode_nxt   = MODE_PAYLOAD;
          end
        end
      end
      default: begin
        mode_nxt = MODE_ALIGNED;
        held_nxt = '0;
      end
    endcase

    discard_nxt = discard_r;
    if (disc_en) begin
      discard_nxt = disc_sum[WORD_W] ? DISCARD_MAX : disc_sum[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_ALIGNED;
      held_r    <= '0;
      remain_r  <= '0;
      discard_r <= '0;
    end else if (in_fire) begin
      mode_r    <= mode_nxt;
      held_r    <= held_nxt;
      remain_r  <= remain_nxt;
      discard_r <= discard_nxt;
    end
  end

  // held header bytes, every slot is written before it is read
  always_ff @(posedge clk) begin
    if (in_fire && hdr_wr) begin
      hdr_r[held_r] <= in_tdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_kind_r  <= res_kind;
      out_byte_r  <= res_byte;
      out_words_r <= res_words;
      out_last_r  <= res_last;
      out_disc_r  <= discard_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_disc_r, out_words_r, out_byte_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // error results always close their run
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_LEN_SHORT || out_tuser == KIND_TOO_LARGE) |-> out_tlast)
    else $error("error result without last");

  // discard count only grows
  a_disc_mono: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> discard_r >= $past(discard_r))
    else $error("discard count went down");

  // payload mode always has bytes left to pass
  a_pay_remain: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_PAYLOAD |-> remain_r != '0)
    else $error("payload mode with nothing remaining");

  // hunting never holds a full sync word
  a_hunt_held: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_HUNT |-> held_r < HELD_HUNT_DONE)
    else $error("hunt holds too many bytes");

endmodule

// ===== verif/sync_word_length_deframer_test.sv =====
// self-checking testbench for sync_word_length_deframer: drives a byte stream and
// register writes, predicts every result in a scoreboard class and checks them in order
// depends on swld_pkg and the sync_word_length_deframer rtl
`timescale 1ns / 1ps

module sync_word_length_deframer_test;
  import swld_pkg::*;

  localparam int unsigned PERIOD_NS       = 10;
  localparam int unsigned RESET_CYCLES    = 9;
  localparam int unsigned TIMEOUT_NS      = 2_000_000;
  localparam int unsigned DRAIN_LIMIT     = 20_000;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned RANDOM_BYTES    = 1100;
  localparam int unsigned RANDOM_PHASES   = 6;
  localparam int unsigned MAX_FRAME_WORDS = 14;
  localparam int unsigned MAX_REPORTS     = 10;

  // register indexes past the list, which the block must ignore
  localparam logic [CIDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  data;
    logic [WORD_W-1:0]  words;
    logic               last;
    logic [WORD_W-1:0]  discards;
  } frame_result_t;

  class frame_checker;
    logic [HSIZE_W-1:0] hdr_size;
    logic [WORD_W-1:0]  max_pay;
    mode_t              mode;
    logic [HOLD_W-1:0]  held;
    logic [63:0]        hdr;
    logic [LEN_W-1:0]   remaining;
    logic [WORD_W-1:0]  discards;
    frame_result_t      pending_results[$];
    int unsigned        errors;

    function new();
      hdr_size  = HSIZE_RST;
      max_pay   = MAXPAY_RST;
      mode      = MODE_ALIGNED;
      held      = '0;
      hdr       = '0;
      remaining = '0;
      discards  = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [WORD_W-1:0] value);
      case (idx)
        CFG_HEADER_SIZE: hdr_size = value[HSIZE_W-1:0];
        CFG_MAX_PAYLOAD: max_pay = value;
        default: ;
      endcase
    endfunction

    function void add_discard(int unsigned n);
      logic [WORD_W:0] sum;
      sum = {1'b0, discards} + (WORD_W + 1)'(n);
      discards = sum[WORD_W] ? DISCARD_MAX : sum[WORD_W-1:0];
    endfunction

    function void push(kind_t kind, logic [BYTE_W-1:0] data, logic [WORD_W-1:0] words,
                       logic last);
      frame_result_t r;
      r.kind     = kind;
      r.data     = data;
      r.words    = words;
      r.last     = last;
      r.discards = discards;
      pending_results.push_back(r);
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
      logic [WORD_W-1:0] w0;
      logic [WORD_W-1:0] w1;
      logic [LEN_W-1:0]  plen;
      case (mode)
        MODE_PAYLOAD: begin
          remaining = remaining - 1'b1;
          if (remaining == '0) begin
            mode = MODE_ALIGNED;
            held = '0;
            push(KIND_BYTE, b, '0, 1'b1);
          end else begin
            push(KIND_BYTE, b, '0, 1'b0);
          end
        end
        MODE_HUNT: begin
          if (b != SYNC_BYTE) begin
            // broken run: held sync bytes and this one are thrown away
            add_discard(int'(held) + 1);
            held = '0;
            hdr  = '0;
          end else begin
            hdr[held*8 +: 8] = b;
            held = held + 1'b1;
            if (held == HELD_HUNT_DONE) mode = MODE_ALIGNED;
          end
        end
        default: begin
          hdr[held*8 +: 8] = b;
          if (held != HELD_HDR_LAST) begin
            held = held + 1'b1;
          end else begin
            held = '0;
            w0   = hdr[WORD_W-1:0];
            w1   = hdr[2*WORD_W-1:WORD_W];
            plen = {w1, 2'b00};
            hdr  = '0;
            if (w0 != SYNC_WORD) begin
              add_discard(int'(HDR_BYTES));
              mode = MODE_HUNT;
            end else if (plen < LEN_W'(hdr_size)) begin
              push(KIND_LEN_SHORT, '0, w1, 1'b1);
            end else if (plen - LEN_W'(hdr_size) > LEN_W'(max_pay)) begin
              push(KIND_TOO_LARGE, '0, w1, 1'b1);
            end else if (plen <= HDR_BYTES) begin
              remaining = '0;
              push(KIND_HEADER, '0, w1, 1'b1);
            end else begin
              remaining = plen - HDR_BYTES;
              mode = MODE_PAYLOAD;
              push(KIND_HEADER, '0, w1, 1'b0);
            end
          end
        end
      endcase
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function void check_result(kind_t kind, logic [BYTE_W-1:0] data,
                               logic [WORD_W-1:0] words, logic last,
                               logic [WORD_W-1:0] discards_seen);
      frame_result_t e;
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result: kind %0d byte %h words %h last %b disc %0d",
                             kind, data, words, last, discards_seen));
        return;
      end
      e = pending_results.pop_front();
      if (kind !== e.kind || data !== e.data || words !== e.words || last !== e.last ||
          discards_seen !== e.discards) begin
        note_error($sformatf({"mismatch: expected kind %0d byte %h words %h last %b disc %0d,",
                              " got kind %0d byte %h words %h last %b disc %0d"},
                             e.kind, e.data, e.words, e.last, e.discards,
                             kind, data, words, last, discards_seen));
      end
    endfunction

    function void flag_leftovers();
      if (pending_results.size() != 0)
        note_error($sformatf("%0d expected results never arrived", pending_results.size()));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [BYTE_W-1:0]   in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;   // [7:0] byte_out, [39:8] packet_words,
                                    // [71:40] discarded_total
  logic [KIND_W-1:0]   out_tuser;   // [1:0] kind
  logic                out_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [WORD_W-1:0]   cfg_data = '0;

  frame_checker sb;
  int unsigned  send_idle = 14;
  int unsigned  recv_idle = 56;
  int unsigned  bytes_sent = 0;

  sync_word_length_deframer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #(PERIOD_NS / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // sample both streams with the values present at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.take_byte(in_tdata);
      if (out_tvalid && out_tready)
        sb.check_result(kind_t'(out_tuser), out_tdata[BYTE_W-1:0],
                        out_tdata[BYTE_W +: WORD_W], out_tlast,
                        out_tdata[BYTE_W+WORD_W +: WORD_W]);
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [WORD_W-1:0] w);
    for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8]);
  endtask

  task automatic send_header(input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1);
    send_word(w0);
    send_word(w1);
  endtask

  // header with a length the block accepts, followed by the rest of the packet
  task automatic send_frame(input int unsigned words);
    send_header(SYNC_WORD, words);
    if (words * 4 > HDR_BYTES)
      repeat (words * 4 - HDR_BYTES) send_byte(BYTE_W'($urandom_range(255)));
  endtask

  function automatic logic [BYTE_W-1:0] non_sync_byte();
    logic [BYTE_W-1:0] v;
    v = BYTE_W'($urandom_range(254));
    if (v >= SYNC_BYTE) v = v + 1'b1;
    return v;
  endfunction

  // sender holds off until every expected result is out, then the block settles
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    for (int w = 0; w < DRAIN_LIMIT && sb.pending_results.size() != 0; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [WORD_W-1:0] hsize_data,
                            input logic [WORD_W-1:0] maxpay_data);
    drain();
    write_reg(CFG_HEADER_SIZE, hsize_data);
    write_reg(CFG_MAX_PAYLOAD, maxpay_data);
  endtask

  task automatic send_random_sequence();
    int unsigned pick;
    int unsigned hs;
    int unsigned mp;
    int unsigned lo;
    int unsigned hi;
    logic [WORD_W-1:0] bad;
    int unsigned k;
    pick = $urandom_range(99);
    hs = 32'(sb.hdr_size);
    mp = sb.max_pay;
    lo = (hs + 3) / 4;
    hi = (hs + mp) / 4;
    if (hi > MAX_FRAME_WORDS) hi = MAX_FRAME_WORDS;
    if (pick < 60 && lo <= hi) begin
      send_frame($urandom_range(hi, lo));
    end else if (pick < 70 && hs > 0) begin
      send_header(SYNC_WORD, $urandom_range((hs - 1) / 4, 0));
    end else if (pick < 78) begin
      if ($urandom_range(1)) send_header(SYNC_WORD, $urandom());
      else send_header(SYNC_WORD, (hs + mp) / 4 + 1 + $urandom_range(3));
    end else if (pick < 90) begin
      // bad sync word, a few broken runs in the hunt, then a clean or too-large packet
      bad = $urandom();
      k = $urandom_range(3);
      bad[8*k +: 8] = non_sync_byte();
      send_header(bad, $urandom());
      repeat ($urandom_range(3)) begin
        repeat ($urandom_range(3)) send_byte(SYNC_BYTE);
        send_byte(non_sync_byte());
      end
      if (lo <= hi) send_frame($urandom_range(hi, lo));
      else send_header(SYNC_WORD, (hs + mp) / 4 + 1);
    end else begin
      repeat ($urandom_range(12, 1)) send_byte(BYTE_W'($urandom_range(255)));
    end
  endtask

  initial begin
    int unsigned target;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limits: short length at the boundary, then a bad header and a hunt
    send_header(SYNC_WORD, 32'd7);
    send_header(32'hAAAA_AA00, 32'hFFFF_FFFF);
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_header(SYNC_WORD, 32'h0000_4009);

    // header-only packet and the smallest payload limit
    set_limits(32'd8, 32'd0);
    write_reg(CFG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_B, 32'd0);
    send_header(SYNC_WORD, 32'd2);
    send_header(SYNC_WORD, 32'd3);

    // header size below the header itself, widest payload limit
    set_limits(32'd0, 32'hFFFF_FFFF);
    send_header(SYNC_WORD, 32'd0);
    send_header(SYNC_WORD, 32'd1);
    send_header(SYNC_WORD, 32'hFFFF_FFFF);
    send_frame(5);

    // largest header size; upper data bits must not reach the register
    set_limits(32'hFFFF_FFFF, 32'd0);
    send_header(SYNC_WORD, 32'h0000_3FFF);
    send_header(SYNC_WORD, 32'h0000_4000);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 2) begin
        send_idle = 14;
        recv_idle = 56;
      end else if (p < 4) begin
        send_idle = 56;
        recv_idle = 14;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      set_limits({16'($urandom()), 16'($urandom_range(48))}, $urandom_range(64));
      if ($urandom_range(1)) write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom());
      target = bytes_sent + RANDOM_BYTES / RANDOM_PHASES;
      while (bytes_sent < target) send_random_sequence();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
